@@ hw/rtl/assert_macros.svh @@
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, clocked on clk_i, off during reset
`define PCCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk_i, off during reset
`define PCCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCCP_ASSERT_IMP(lbl, ante, cons, msg)
`define PCCP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/pccp_pkg.sv @@
// Types and constants of the pair contact constraint projection block
package pccp_pkg;

  localparam int IDX_W    = 10;
  localparam int POS_W    = 24;
  localparam int DIFF_W   = POS_W + 1;
  localparam int MASS_W   = 16;
  localparam int MSUM_W   = MASS_W + 1;
  localparam int RADIUS_W = 16;
  localparam int SUB_W    = 7;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int ROOT_W   = DIFF_W;
  localparam int ERR_W    = ROOT_W + 2;
  localparam int MAG_W    = ROOT_W;
  localparam int NUM_W    = 50;
  localparam int DEN_W    = 25;
  localparam int QUO_W    = NUM_W - DEN_W;
  localparam int EXT_W    = POS_W + 3;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = QUO_W;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // register indexes
  localparam logic REG_RADIUS   = 1'b0;
  localparam logic REG_SUBSTEPS = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET  = RADIUS_W'(1280);
  localparam logic [SUB_W-1:0]    SUBSTEP_RESET = SUB_W'(8);

  localparam logic signed [EXT_W-1:0] POS_MAX_X = EXT_W'((2 ** (POS_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] POS_MIN_X = -EXT_W'(2 ** (POS_W - 1));

  typedef struct packed {
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic [MASS_W-1:0]       first_mass;
    logic [MASS_W-1:0]       second_mass;
  } pccp_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_first_index;
    logic [IDX_W-1:0]        out_second_index;
    logic signed [POS_W-1:0] new_first_x;
    logic signed [POS_W-1:0] new_first_y;
    logic signed [POS_W-1:0] new_second_x;
    logic signed [POS_W-1:0] new_second_y;
    logic                    was_clamped;
  } pccp_out_t;

  // per-pair state carried down the pipeline
  typedef struct packed {
    logic [IDX_W-1:0]         idx_i;
    logic [IDX_W-1:0]         idx_j;
    logic signed [POS_W-1:0]  xi;
    logic signed [POS_W-1:0]  yi;
    logic signed [POS_W-1:0]  xj;
    logic signed [POS_W-1:0]  yj;
    logic [MASS_W-1:0]        mi;
    logic [MASS_W-1:0]        mj;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [ROOT_W-1:0]        len;
    logic                     neg;
    logic                     clamped;
  } pccp_side_t;

endpackage

@@ hw/rtl/pccp_sqrt.sv @@
// Pipelined integer square root, one result bit per stage
module pccp_sqrt import pccp_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_W-1:0] v_q [SQRT_STAGES];
  logic [SQ_W-1:0] r_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
    localparam int Shift = 2 * (ROOT_W - 1 - k);
    logic [SQ_W-1:0] v_in, r_in, bitv, trial;

    if (k == 0) begin : g_first
      assign v_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign bitv  = SQ_W'(1) << Shift;
    assign trial = r_in + bitv;

    // take one digit of the root
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= trial) begin
          v_q[k] <= v_in - trial;
          r_q[k] <= (r_in >> 1) + bitv;
        end else begin
          v_q[k] <= v_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

@@ hw/rtl/pccp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage
module pccp_div import pccp_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [DIV_STAGES];
  logic [QUO_W-1:0] low_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [DEN_W-1:0] rem_in, den_in;
    logic [QUO_W-1:0] low_in, quo_in;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i[NUM_W-1:QUO_W];
      assign low_in = num_i[QUO_W-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    // shift in one numerator bit, subtract where it fits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_q[k] <= low_in << 1;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

@@ hw/rtl/pair_contact_constraint_projection.sv @@
// Top level of the pair contact constraint projection pipeline
//
// Usage: one word on the input channel is a pair of particles (indices,
// Q15.8 positions, Q8.8 masses); one word on the output channel is the
// same pair with corrected, saturated positions and a clamp flag.
// Both channels use valid/stall; a word moves when valid is high and
// stall is low. Radius and substep count sit in two APB registers at
// byte addresses 0 and 4; write them only while the block is empty.
// Throughput: one pair per cycle while in_stall_o is low. The depth is
// set mostly by the 25-stage square root and two ranks of 25-stage
// dividers in series, one quotient bit per stage.
// A two-word output buffer parts the sides: while one result waits,
// the pipeline keeps taking pairs; it stops (in_stall_o high) only when
// both buffer words are full, and resumes the cycle after one is taken.
// Reset (rst_ni low) empties the pipeline and the buffer and returns the
// radius to 1280 and the substep count to 8.
`include "assert_macros.svh"

module pair_contact_constraint_projection import pccp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pccp_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pccp_out_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int PM_W  = MAG_W + MASS_W;
  localparam int PMS_W = PM_W + SUB_W;
  localparam int RMS_W = RADIUS_W + MSUM_W;
  localparam int RMN_W = RADIUS_W + MASS_W;
  localparam int SM_W  = SUB_W + MASS_W;
  localparam int PP_W  = QUO_W + POS_W;

  function automatic logic signed [EXT_W-1:0] signed_move(logic [QUO_W-1:0] m, logic flip);
    logic signed [EXT_W-1:0] mv;
    mv = signed'({{(EXT_W - QUO_W){1'b0}}, m});
    return flip ? -mv : mv;
  endfunction

  function automatic logic signed [EXT_W-1:0] ext_pos(logic signed [POS_W-1:0] p);
    return signed'({{(EXT_W - POS_W){p[POS_W-1]}}, p});
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] c;
    c = v;
    if (v > POS_MAX_X) c = POS_MAX_X;
    if (v < POS_MIN_X) c = POS_MIN_X;
    return c[POS_W-1:0];
  endfunction

  // ---------------------------------------------------------------- registers
  logic [RADIUS_W-1:0] radius_q;
  logic [SUB_W-1:0]    substeps_q;
  logic [SUB_W-1:0]    s_eff;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign s_eff  = (substeps_q == '0) ? SUB_W'(1) : substeps_q;

  // hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RADIUS_RESET;
      substeps_q <= SUBSTEP_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_RADIUS:   radius_q   <= pwdata[RADIUS_W-1:0];
        REG_SUBSTEPS: substeps_q <= pwdata[SUB_W-1:0];
        default:      ;
      endcase
    end
  end

  // read back; misaligned addresses read as zero
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        REG_RADIUS:   prdata = PDATA_W'(radius_q);
        REG_SUBSTEPS: prdata = PDATA_W'(substeps_q);
        default:      prdata = '0;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic      en;
  logic      v0_q, v1_q, v0_d, v1_d;
  pccp_out_t buf0_q, buf1_q, buf0_d, buf1_d;
  logic      pop, push;

  assign en         = !v1_q;
  assign in_stall_o = v1_q;

  logic                   a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q, g_v_q, h_v_q, i_v_q;
  logic [SQRT_STAGES-1:0] sq_v_q;
  logic [DIV_STAGES-1:0]  dv1_v_q, dv2_v_q;

  // advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      sq_v_q  <= '0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      f_v_q   <= 1'b0;
      g_v_q   <= 1'b0;
      dv1_v_q <= '0;
      h_v_q   <= 1'b0;
      i_v_q   <= 1'b0;
      dv2_v_q <= '0;
    end else if (en) begin
      a_v_q   <= in_valid_i;
      b_v_q   <= a_v_q;
      c_v_q   <= b_v_q;
      sq_v_q  <= {sq_v_q[SQRT_STAGES-2:0], c_v_q};
      d_v_q   <= sq_v_q[SQRT_STAGES-1];
      e_v_q   <= d_v_q;
      f_v_q   <= e_v_q;
      g_v_q   <= f_v_q;
      dv1_v_q <= {dv1_v_q[DIV_STAGES-2:0], g_v_q};
      h_v_q   <= dv1_v_q[DIV_STAGES-1];
      i_v_q   <= h_v_q;
      dv2_v_q <= {dv2_v_q[DIV_STAGES-2:0], i_v_q};
    end
  end

  // ---------------------------------------------------------------- stage A
  pccp_side_t a_d, a_q;

  // form the separation vector, lift zero masses to one
  always_comb begin
    a_d              = '0;
    a_d.idx_i        = in_data_i.first_index;
    a_d.idx_j        = in_data_i.second_index;
    a_d.xi           = in_data_i.first_x;
    a_d.yi           = in_data_i.first_y;
    a_d.xj           = in_data_i.second_x;
    a_d.yj           = in_data_i.second_y;
    a_d.mi           = (in_data_i.first_mass == '0) ? MASS_W'(1) : in_data_i.first_mass;
    a_d.mj           = (in_data_i.second_mass == '0) ? MASS_W'(1) : in_data_i.second_mass;
    a_d.dx           = {in_data_i.second_x[POS_W-1], in_data_i.second_x}
                     - {in_data_i.first_x[POS_W-1], in_data_i.first_x};
    a_d.dy           = {in_data_i.second_y[POS_W-1], in_data_i.second_y}
                     - {in_data_i.first_y[POS_W-1], in_data_i.first_y};
  end

  // ---------------------------------------------------------------- stages B, C
  pccp_side_t b_q, c_q;
  logic signed [SQ_W-1:0] dxx_w, dyy_w;
  logic [SQ_W-2:0] dxx_q, dyy_q;
  logic [SQ_W-1:0] sum_q;

  assign dxx_w = a_q.dx * a_q.dx;
  assign dyy_w = a_q.dy * a_q.dy;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      b_q   <= a_q;
      dxx_q <= dxx_w[SQ_W-2:0];
      dyy_q <= dyy_w[SQ_W-2:0];
      c_q   <= b_q;
      sum_q <= {1'b0, dxx_q} + {1'b0, dyy_q};
    end
  end

  // ---------------------------------------------------------------- length
  logic [ROOT_W-1:0] root;
  pccp_side_t        sq_q [SQRT_STAGES];

  pccp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (root)
  );

  // carry the pair alongside the root
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= c_q;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sq_q[k] <= sq_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage D
  pccp_side_t              d_d, d_q;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        mag_w;
  logic [MAG_W-1:0]        mag_q;
  logic [MASS_W-1:0]       mmax_q, mmin_q;
  logic [MSUM_W-1:0]       msum_q;

  assign err   = signed'({2'b00, root}) - signed'({{(ERR_W - RADIUS_W - 1){1'b0}}, radius_q, 1'b0});
  assign mag_w = err[ERR_W-1] ? -err : err;

  always_comb begin
    d_d     = sq_q[SQRT_STAGES-1];
    d_d.len = root;
    d_d.neg = err[ERR_W-1];
  end

  // ---------------------------------------------------------------- stages E, F
  pccp_side_t        e_q, f_q;
  logic [PM_W-1:0]   pm_q, magmj_q, magmi_q, magmj_f, magmi_f;
  logic [RMS_W-1:0]  rms_q, rms_f;
  logic [RMN_W-1:0]  rmn_q, rmn_f;
  logic [SM_W-1:0]   smi_q, smj_q, smi_f, smj_f;
  logic [MSUM_W-1:0] msum_e, msum_f;
  logic [PMS_W-1:0]  pms_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q     <= d_d;
      mag_q   <= mag_w[MAG_W-1:0];
      mmax_q  <= (d_d.mi > d_d.mj) ? d_d.mi : d_d.mj;
      mmin_q  <= (d_d.mi > d_d.mj) ? d_d.mj : d_d.mi;
      msum_q  <= MSUM_W'(d_d.mi) + MSUM_W'(d_d.mj);
      // products of the clamp test and the correction sizes
      e_q     <= d_q;
      pm_q    <= PM_W'(mag_q) * PM_W'(mmax_q);
      rms_q   <= RMS_W'(radius_q) * RMS_W'(msum_q);
      rmn_q   <= RMN_W'(radius_q) * RMN_W'(mmin_q);
      smi_q   <= SM_W'(s_eff) * SM_W'(d_q.mi);
      smj_q   <= SM_W'(s_eff) * SM_W'(d_q.mj);
      magmj_q <= PM_W'(mag_q) * PM_W'(d_q.mj);
      magmi_q <= PM_W'(mag_q) * PM_W'(d_q.mi);
      msum_e  <= msum_q;
      // scale the test product by the substep count
      f_q     <= e_q;
      pms_q   <= PMS_W'(pm_q) * PMS_W'(s_eff);
      rms_f   <= rms_q;
      rmn_f   <= rmn_q;
      smi_f   <= smi_q;
      smj_f   <= smj_q;
      magmj_f <= magmj_q;
      magmi_f <= magmi_q;
      msum_f  <= msum_e;
    end
  end

  // ---------------------------------------------------------------- stage G
  pccp_side_t       g_d, g_q;
  logic             clamped;
  logic [NUM_W-1:0] num_i_q, num_j_q;
  logic [DEN_W-1:0] den_i_q, den_j_q;

  assign clamped = pms_q > PMS_W'(rms_f);

  always_comb begin
    g_d         = f_q;
    g_d.clamped = clamped;
  end

  // pick the division for each correction size, with half the divisor for rounding
  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q <= g_d;
      if (clamped) begin
        num_i_q <= NUM_W'(rmn_f) + NUM_W'(smi_f >> 1);
        num_j_q <= NUM_W'(rmn_f) + NUM_W'(smj_f >> 1);
        den_i_q <= DEN_W'(smi_f);
        den_j_q <= DEN_W'(smj_f);
      end else begin
        num_i_q <= NUM_W'(magmj_f) + NUM_W'(msum_f >> 1);
        num_j_q <= NUM_W'(magmi_f) + NUM_W'(msum_f >> 1);
        den_i_q <= DEN_W'(msum_f);
        den_j_q <= DEN_W'(msum_f);
      end
    end
  end

  // ---------------------------------------------------------------- correction sizes
  logic [QUO_W-1:0] di, dj;
  pccp_side_t       dv1_q [DIV_STAGES];

  pccp_div u_div_di (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_i_q),
    .den_i (den_i_q),
    .quo_o (di)
  );

  pccp_div u_div_dj (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_j_q),
    .den_i (den_j_q),
    .quo_o (dj)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv1_q[0] <= g_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv1_q[k] <= dv1_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stages H, I
  pccp_side_t       h_q, i_q;
  logic [DIFF_W-1:0] ax_w, ay_w;
  logic [PP_W-1:0]  pix_q, piy_q, pjx_q, pjy_q;
  logic [NUM_W-1:0] nix_q, niy_q, njx_q, njy_q;

  assign ax_w = dv1_q[DIV_STAGES-1].dx[DIFF_W-1] ? -dv1_q[DIV_STAGES-1].dx
                                                 : dv1_q[DIV_STAGES-1].dx;
  assign ay_w = dv1_q[DIV_STAGES-1].dy[DIFF_W-1] ? -dv1_q[DIV_STAGES-1].dy
                                                 : dv1_q[DIV_STAGES-1].dy;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q   <= dv1_q[DIV_STAGES-1];
      pix_q <= PP_W'(di) * PP_W'(ax_w[POS_W-1:0]);
      piy_q <= PP_W'(di) * PP_W'(ay_w[POS_W-1:0]);
      pjx_q <= PP_W'(dj) * PP_W'(ax_w[POS_W-1:0]);
      pjy_q <= PP_W'(dj) * PP_W'(ay_w[POS_W-1:0]);
      // add half the length for rounding
      i_q   <= h_q;
      nix_q <= NUM_W'(pix_q) + NUM_W'(h_q.len >> 1);
      niy_q <= NUM_W'(piy_q) + NUM_W'(h_q.len >> 1);
      njx_q <= NUM_W'(pjx_q) + NUM_W'(h_q.len >> 1);
      njy_q <= NUM_W'(pjy_q) + NUM_W'(h_q.len >> 1);
    end
  end

  // ---------------------------------------------------------------- component moves
  logic [QUO_W-1:0] qix, qiy, qjx, qjy;
  pccp_side_t       dv2_q [DIV_STAGES];

  pccp_div u_div_ix (.clk_i(clk_i), .en_i(en), .num_i(nix_q), .den_i(i_q.len), .quo_o(qix));
  pccp_div u_div_iy (.clk_i(clk_i), .en_i(en), .num_i(niy_q), .den_i(i_q.len), .quo_o(qiy));
  pccp_div u_div_jx (.clk_i(clk_i), .en_i(en), .num_i(njx_q), .den_i(i_q.len), .quo_o(qjx));
  pccp_div u_div_jy (.clk_i(clk_i), .en_i(en), .num_i(njy_q), .den_i(i_q.len), .quo_o(qjy));

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv2_q[0] <= i_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv2_q[k] <= dv2_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- final sums
  pccp_side_t j_s;
  pccp_out_t  j_out;
  logic       len_zero, flip_x, flip_y;

  assign j_s      = dv2_q[DIV_STAGES-1];
  assign len_zero = (j_s.len == '0);
  assign flip_x   = j_s.dx[DIFF_W-1] ^ j_s.neg;
  assign flip_y   = j_s.dy[DIFF_W-1] ^ j_s.neg;

  // apply the moves and saturate; coincident pairs stay put
  always_comb begin
    j_out.out_first_index  = j_s.idx_i;
    j_out.out_second_index = j_s.idx_j;
    j_out.was_clamped      = j_s.clamped;
    if (len_zero) begin
      j_out.new_first_x  = j_s.xi;
      j_out.new_first_y  = j_s.yi;
      j_out.new_second_x = j_s.xj;
      j_out.new_second_y = j_s.yj;
    end else begin
      j_out.new_first_x  = sat_pos(ext_pos(j_s.xi) + signed_move(qix, flip_x));
      j_out.new_first_y  = sat_pos(ext_pos(j_s.yi) + signed_move(qiy, flip_y));
      j_out.new_second_x = sat_pos(ext_pos(j_s.xj) - signed_move(qjx, flip_x));
      j_out.new_second_y = sat_pos(ext_pos(j_s.yj) - signed_move(qjy, flip_y));
    end
  end

  // ---------------------------------------------------------------- output buffer
  assign push = en && dv2_v_q[DIV_STAGES-1];
  assign pop  = v0_q && !out_stall_i;

  // drop the taken word, then fill the first free slot
  always_comb begin
    v0_d   = v0_q;
    v1_d   = v1_q;
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    if (pop) begin
      buf0_d = buf1_q;
      v0_d   = v1_q;
      v1_d   = 1'b0;
    end
    if (push) begin
      if (!v0_d) begin
        buf0_d = j_out;
        v0_d   = 1'b1;
      end else begin
        buf1_d = j_out;
        v1_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

  assign out_valid_o = v0_q;
  assign out_data_o  = buf0_q;

  // ---------------------------------------------------------------- checks
  `PCCP_ASSERT_IMP(a_buf_order, v1_q, v0_q, "second buffer word held without a first")
  `PCCP_ASSERT_NXT(a_buf_hold, v1_q && out_stall_i, v1_q && $stable(buf1_q), "waiting word lost")
  `PCCP_ASSERT_IMP(a_clamp_bound, dv1_v_q[DIV_STAGES-1] && dv1_q[DIV_STAGES-1].clamped, (di <= QUO_W'(radius_q)) && (dj <= QUO_W'(radius_q)), "clamped size above radius")
  `PCCP_ASSERT_IMP(a_still_pair, push && len_zero, (j_out.new_first_x == j_s.xi) && (j_out.new_second_y == j_s.yj), "coincident pair moved")

endmodule
